### rtl/blcr_pkg.sv
// ----------------------------------------------------------------------------
// blcr_pkg
// Shared widths, reset values and codes for the border line color recorder.
// ----------------------------------------------------------------------------
package blcr_pkg;

  localparam int LINES_DEF = 224;

  localparam int FUNC_W  = 2;
  localparam int COLOR_W = 3;
  localparam int TICK_W  = 17;
  localparam int IDX_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [TICK_W-1:0]  START_RESET = 17'd4096;
  localparam logic [TICK_W-1:0]  SPAN_RESET  = 17'd65535;
  localparam logic [COLOR_W-1:0] COLOR_CLEAR = 3'h7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 1'b0,
    CFG_SPAN  = 1'b1
  } cfg_reg_t;

endpackage

### rtl/border_line_color_recorder.sv
// ----------------------------------------------------------------------------
// border_line_color_recorder
// Builds a per-line border color table from timed color writes.
// ----------------------------------------------------------------------------
// Read request: CALC, RDW, then OUT, which waits for a free output register.
// Color write in the window: CALC, the divider in DIV, FILL up to the hit
//   line, then PUT stores the color while the pointer is below LINES.
// Write outside the window: CALC only. Frame end: CALC, then FILL to the end.
// One request at a time; the bit-serial divider sets the write latency.
// Reset (sync, active low): a sweep in CLEAR writes 7 to every line first.
// ----------------------------------------------------------------------------
module border_line_color_recorder #(
  parameter int LINES = blcr_pkg::LINES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [blcr_pkg::FUNC_W-1:0]    in_func,
  input  logic [blcr_pkg::COLOR_W-1:0]   in_new_color,
  input  logic [blcr_pkg::TICK_W-1:0]    in_tick_time,
  input  logic [blcr_pkg::IDX_W-1:0]     in_line_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [blcr_pkg::COLOR_W-1:0]   out_line_color,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [blcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blcr_pkg::TICK_W-1:0]    cfg_data
);

  localparam int TW     = blcr_pkg::TICK_W;
  localparam int CW     = blcr_pkg::COLOR_W;
  localparam int PTR_W  = $clog2(LINES + 1);     // fill pointer holds 0..LINES
  localparam int ADDR_W = $clog2(LINES);
  localparam int NUM_W  = TW + PTR_W;            // (tick - start) * LINES
  localparam int CMP_W  = (PTR_W > blcr_pkg::IDX_W) ? PTR_W : blcr_pkg::IDX_W;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,  // post-reset sweep writing color 7
    ST_IDLE  = 8'b0000_0010,
    ST_CALC  = 8'b0000_0100,  // window check, product into divider
    ST_DIV   = 8'b0000_1000,
    ST_FILL  = 8'b0001_0000,  // one line of last color per cycle
    ST_PUT   = 8'b0010_0000,  // store the new color
    ST_RDW   = 8'b0100_0000,  // RAM read data arriving
    ST_OUT   = 8'b1000_0000   // wait for the output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [TW-1:0] start_r, start_nxt;
  logic [TW-1:0] span_r, span_nxt;

  // captured request
  logic [blcr_pkg::FUNC_W-1:0] func_r;
  logic [CW-1:0]               color_r;
  logic [TW-1:0]               tick_r;
  logic [blcr_pkg::IDX_W-1:0]  idx_r;

  // recorder state
  logic [PTR_W-1:0] fill_ptr_r, fill_ptr_nxt;
  logic [PTR_W-1:0] limit_r, limit_nxt;
  logic [CW-1:0]    last_color_r, last_color_nxt;
  logic [CW-1:0]    rd_color_r, rd_color_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_color_r, out_color_nxt;

  // datapath
  logic              in_window;
  logic [TW-1:0]     diff;
  logic [NUM_W-1:0]  product;
  logic [TW-1:0]     den;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [PTR_W-1:0]  line_clamped;
  logic              idx_in_range;
  logic              ptr_below_lines;

  // store access
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CW-1:0]     ram_rdata;

  logic in_fire;
  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Window is [start, start + span], inclusive on both ends.
  assign in_window = (tick_r >= start_r) &&
                     ({1'b0, tick_r} <= ({1'b0, start_r} + {1'b0, span_r}));
  assign diff      = tick_r - start_r;
  assign product   = NUM_W'(diff) * NUM_W'(LINES);
  assign den       = (span_r == '0) ? TW'(1) : span_r;   // zero span acts as 1
  assign div_start = (state_r == ST_CALC) && (func_r == blcr_pkg::FUNC_WRITE) &&
                     in_window;

  assign line_clamped = (div_quot > NUM_W'(LINES)) ? PTR_W'(LINES)
                                                   : div_quot[PTR_W-1:0];

  assign idx_in_range    = CMP_W'(idx_r) < CMP_W'(LINES);
  assign ptr_below_lines = fill_ptr_r < PTR_W'(LINES);
  assign ram_raddr       = ADDR_W'(idx_r);

  blcr_div #(
    .NUM_W (NUM_W),
    .DEN_W (TW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (product),
    .denom (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  blcr_ram #(
    .WIDTH (CW),
    .DEPTH (LINES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Store writes: clearing sweep, line fill, new color.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_ptr_r[ADDR_W-1:0];
    ram_wdata = last_color_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = blcr_pkg::COLOR_CLEAR;
      end
      ST_FILL: begin
        ram_we = fill_ptr_r < limit_r;
      end
      ST_PUT: begin
        ram_we    = ptr_below_lines;
        ram_wdata = color_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_ptr_nxt   = fill_ptr_r;
    limit_nxt      = limit_r;
    last_color_nxt = last_color_r;
    rd_color_nxt   = rd_color_r;
    out_valid_nxt  = out_valid_r;
    out_color_nxt  = out_color_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        if (fill_ptr_r == PTR_W'(LINES - 1)) begin
          fill_ptr_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          fill_ptr_nxt = fill_ptr_r + PTR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        case (func_r)
          blcr_pkg::FUNC_WRITE: begin
            if (in_window) begin
              state_nxt = ST_DIV;
            end else begin
              last_color_nxt = color_r;
              state_nxt      = ST_IDLE;
            end
          end
          blcr_pkg::FUNC_FRAME: begin
            limit_nxt = PTR_W'(LINES);
            state_nxt = ST_FILL;
          end
          blcr_pkg::FUNC_READ: begin
            state_nxt = ST_RDW;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          limit_nxt = line_clamped;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_ptr_r < limit_r) begin
          fill_ptr_nxt = fill_ptr_r + PTR_W'(1);
        end else if (func_r == blcr_pkg::FUNC_FRAME) begin
          fill_ptr_nxt = '0;   // rewind for the next frame
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (ptr_below_lines) begin
          fill_ptr_nxt = fill_ptr_r + PTR_W'(1);
        end
        last_color_nxt = color_r;
        state_nxt      = ST_IDLE;
      end
      ST_RDW: begin
        rd_color_nxt = idx_in_range ? ram_rdata : '0;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = rd_color_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    start_nxt = start_r;
    span_nxt  = span_r;
    if (cfg_we) begin
      case (cfg_index)
        blcr_pkg::CFG_START: start_nxt = cfg_data;
        blcr_pkg::CFG_SPAN:  span_nxt  = cfg_data;
        default:             start_nxt = start_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      start_r      <= blcr_pkg::START_RESET;
      span_r       <= blcr_pkg::SPAN_RESET;
      fill_ptr_r   <= '0;
      last_color_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      span_r       <= span_nxt;
      fill_ptr_r   <= fill_ptr_nxt;
      last_color_r <= last_color_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    limit_r     <= limit_nxt;
    rd_color_r  <= rd_color_nxt;
    out_color_r <= out_color_nxt;
    if (in_fire) begin
      func_r  <= in_func;
      color_r <= in_new_color;
      tick_r  <= in_tick_time;
      idx_r   <= in_line_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_color = out_color_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_ptr_r <= PTR_W'(LINES))
    else $error("fill pointer past last line");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("new request taken while busy");

endmodule

### rtl/blcr_ram.sv
// ----------------------------------------------------------------------------
// blcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blcr_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 224
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/blcr_div.sv
// ----------------------------------------------------------------------------
// blcr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blcr_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;   // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = numer;
      den_nxt = denom;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      num_nxt  = {num_r[NUM_W-2:0], fits};
      rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb - border line color recorder testbench
// Drives color writes, frame ends and line reads through the request channel
// under random bursts and output stalls, and walks the window registers
// through their extremes. A scoreboard keeps its own line table, fill
// pointer and last color, and checks every returned line color in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blcr_pkg::*;

  localparam int TICK_MAX      = (1 << TICK_W) - 1;
  // Worst write: divider, a fill of all 224 lines, store. Frame end: up to 224 fills.
  localparam int SETTLE_CYCLES = 300;
  // Long output stall, so the block backs up and drops in_ready.
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 110;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the line table and queues the colors reads should see
  // --------------------------------------------------------------------------
  class line_color_scoreboard;
    logic [COLOR_W-1:0] line_store [LINES_DEF];
    int unsigned        fill_ptr;
    logic [COLOR_W-1:0] last_color;
    logic [TICK_W-1:0]  win_start;
    logic [TICK_W-1:0]  win_span;
    logic [COLOR_W-1:0] expected_colors [$];
    int unsigned        errors;

    function new();
      foreach (line_store[i]) line_store[i] = COLOR_CLEAR;
      fill_ptr   = 0;
      last_color = '0;
      win_start  = START_RESET;
      win_span   = SPAN_RESET;
      errors     = 0;
    endfunction

    function void set_register(cfg_reg_t sel, logic [TICK_W-1:0] value);
      case (sel)
        CFG_START: win_start = value;
        CFG_SPAN:  win_span  = value;
        default: ;
      endcase
    endfunction

    function void fill_lines(int unsigned limit);
      while (fill_ptr < limit && fill_ptr < LINES_DEF) begin
        line_store[fill_ptr] = last_color;
        fill_ptr++;
      end
    endfunction

    function void color_write(logic [COLOR_W-1:0] color, logic [TICK_W-1:0] tick);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned divisor;
      longint unsigned hit_line;
      lo      = win_start;
      hi      = lo + win_span;
      // zero span divides by one: only window_start itself hits, at line 0
      divisor = (win_span == 0) ? 1 : win_span;
      if (tick >= lo && tick <= hi) begin
        hit_line = ((tick - lo) * LINES_DEF) / divisor;
        if (hit_line > LINES_DEF) hit_line = LINES_DEF;
        fill_lines(int'(hit_line));
        // pointer at the end: the color lands nowhere
        if (fill_ptr < LINES_DEF) begin
          line_store[fill_ptr] = color;
          fill_ptr++;
        end
      end
      last_color = color;
    endfunction

    function void note_request(func_t func, logic [COLOR_W-1:0] color,
                               logic [TICK_W-1:0] tick, logic [IDX_W-1:0] idx);
      case (func)
        FUNC_WRITE: color_write(color, tick);
        FUNC_FRAME: begin
          fill_lines(LINES_DEF);
          fill_ptr = 0;
        end
        FUNC_READ: begin
          if (idx < LINES_DEF) expected_colors.push_back(line_store[idx]);
          else expected_colors.push_back(COLOR_W'(0));
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [COLOR_W-1:0] actual);
      logic [COLOR_W-1:0] want;
      if (expected_colors.size() == 0) begin
        $error("line_color %0d returned with no read request pending", actual);
        errors++;
        return;
      end
      want = expected_colors.pop_front();
      if (actual !== want) begin
        $error("line_color mismatch: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_CADENCE} ready_mode_t;

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    in_func;
  logic [COLOR_W-1:0]   in_new_color;
  logic [TICK_W-1:0]    in_tick_time;
  logic [IDX_W-1:0]     in_line_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [COLOR_W-1:0]   out_line_color;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;

  line_color_scoreboard sb = new();

  int unsigned requests_sent;  // requests other than the ignored selector
  int unsigned burst_left;     // requests left in the current sender burst
  int unsigned hold_off_req;   // set by stimulus, picked up by the receiver

  border_line_color_recorder u_top (.*);

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs; a normal run is far shorter.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitors: sample both handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid && in_ready === 1'b1)
      sb.note_request(func_t'(in_func), in_new_color, in_tick_time, in_line_index);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
      sb.check_result(out_line_color);
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready follows a pattern that is redrawn at random times;
  // a hold-off request forces a long stall counted here.
  // --------------------------------------------------------------------------
  initial begin : receiver
    ready_mode_t mode;
    int unsigned mode_left;
    int unsigned hold;
    int unsigned cyc;
    out_ready = 1'b0;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    cyc       = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        hold         = hold_off_req;
        hold_off_req = 0;
        out_ready    = 1'b0;
        repeat (hold) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = ready_mode_t'($urandom_range(3, 0));
        mode_left = $urandom_range(256, 32);
      end
      mode_left--;
      cyc++;
      case (mode)
        RDY_ALWAYS:  out_ready = 1'b1;
        RDY_HALF:    out_ready = 1'($urandom_range(1, 0));
        RDY_SPARSE:  out_ready = ($urandom_range(3, 0) == 0);
        default:     out_ready = (cyc % 3 != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Payload changes at the falling edge; valid stays up
  // through a burst and drops for a random gap when the burst runs out.
  // --------------------------------------------------------------------------
  task automatic send_request(func_t func, logic [COLOR_W-1:0] color,
                              logic [TICK_W-1:0] tick, logic [IDX_W-1:0] idx);
    @(negedge clk);
    in_valid      = 1'b1;
    in_func       = func;
    in_new_color  = color;
    in_tick_time  = tick;
    in_line_index = idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (func != FUNC_NONE) requests_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(6, 0)) @(negedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(8, 1);
    end
  endtask

  task automatic write_color(logic [COLOR_W-1:0] color, logic [TICK_W-1:0] tick);
    send_request(FUNC_WRITE, color, tick, IDX_W'($urandom));
  endtask

  task automatic read_line(logic [IDX_W-1:0] idx);
    send_request(FUNC_READ, COLOR_W'($urandom), TICK_W'($urandom), idx);
  endtask

  task automatic end_frame();
    send_request(FUNC_FRAME, COLOR_W'($urandom), TICK_W'($urandom), IDX_W'($urandom));
  endtask

  // Lower valid, wait for every read result, then let a long write or
  // frame-end fill run out before anything touches the registers.
  task automatic wait_idle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.expected_colors.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_t sel, logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_register(sel, value);
  endtask

  // --------------------------------------------------------------------------
  // Random content helpers
  // --------------------------------------------------------------------------
  // mostly valid lines, some past the end of the table
  function automatic logic [IDX_W-1:0] random_line();
    if ($urandom_range(6, 0) == 0) return IDX_W'($urandom_range(255, LINES_DEF));
    return IDX_W'($urandom_range(LINES_DEF - 1, 0));
  endfunction

  function automatic logic [TICK_W-1:0] window_tick();
    int hi;
    hi = int'(sb.win_start) + int'(sb.win_span);
    if (hi > TICK_MAX) hi = TICK_MAX;
    return TICK_W'($urandom_range(hi, sb.win_start));
  endfunction

  // tick outside the window, below or above, when there is room for one
  function automatic logic [TICK_W-1:0] stray_tick();
    int hi;
    hi = int'(sb.win_start) + int'(sb.win_span);
    if (sb.win_start > 0 && (hi >= TICK_MAX || $urandom_range(1, 0) == 0))
      return TICK_W'($urandom_range(sb.win_start - 1, 0));
    if (hi < TICK_MAX) return TICK_W'($urandom_range(TICK_MAX, hi + 1));
    return TICK_W'($urandom);
  endfunction

  // One frame: time-ordered color writes with reads mixed in, a frame end,
  // then a few reads. Some frames are scrambled or skip the frame end.
  task automatic play_frame();
    logic [TICK_W-1:0] ticks [$];
    repeat ($urandom_range(12, 0))
      ticks.push_back(($urandom_range(9, 0) == 0) ? stray_tick() : window_tick());
    if ($urandom_range(7, 0) != 0) ticks.sort();
    foreach (ticks[i]) begin
      write_color(COLOR_W'($urandom), ticks[i]);
      if ($urandom_range(3, 0) == 0) read_line(random_line());
      if ($urandom_range(40, 0) == 0)
        send_request(FUNC_NONE, COLOR_W'($urandom), TICK_W'($urandom), IDX_W'($urandom));
    end
    if ($urandom_range(9, 0) != 0) end_frame();
    repeat ($urandom_range(6, 1)) read_line(random_line());
  endtask

  // New window setting on an idle block, optional output hold-off, then
  // random frames until the phase has its share of requests.
  task automatic run_phase(logic [TICK_W-1:0] start, logic [TICK_W-1:0] span,
                           bit squeeze);
    int unsigned goal;
    wait_idle();
    write_register(CFG_START, start);
    write_register(CFG_SPAN, span);
    if (squeeze) begin
      // receiver stalls while the sender keeps a burst of reads coming
      hold_off_req = HOLD_CYCLES;
      burst_left   = 16;
      repeat (12) read_line(random_line());
    end
    goal = requests_sent + PHASE_ITEMS;
    while (requests_sent < goal) play_frame();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FUNC_WRITE;
    in_new_color  = '0;
    in_tick_time  = '0;
    in_line_index = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_START;
    cfg_data      = '0;
    requests_sent = 0;
    burst_left    = 0;
    hold_off_req  = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset window (start 4096, span 65535).
    // Fresh table reads 7; reads past the table return 0.
    read_line(IDX_W'(0));
    read_line(IDX_W'(LINES_DEF - 1));
    read_line(IDX_W'(LINES_DEF));
    read_line(IDX_W'(255));
    // ticks before and after the window only move the last color
    write_color(COLOR_W'(5), TICK_W'(0));
    write_color(COLOR_W'(3), TICK_W'(TICK_MAX));
    send_request(FUNC_NONE, COLOR_W'(7), TICK_W'(TICK_MAX), IDX_W'(255));
    // window start -> line 0; mid window -> line 111; window end clamps to
    // the line count and fills the rest with the previous color
    write_color(COLOR_W'(1), TICK_W'(4096));
    write_color(COLOR_W'(6), TICK_W'(36863));
    write_color(COLOR_W'(2), TICK_W'(69631));
    // pointer already at the end: stored nowhere, last color still moves
    write_color(COLOR_W'(4), TICK_W'(5000));
    read_line(IDX_W'(0));
    read_line(IDX_W'(111));
    read_line(IDX_W'(LINES_DEF - 1));
    // frame end with nothing left to fill, then a full-frame fill
    end_frame();
    end_frame();
    read_line(IDX_W'(100));
    write_color(COLOR_W'(7), TICK_W'(4096));
    write_color(COLOR_W'(0), TICK_W'(69632));
    read_line(IDX_W'(0));
    read_line(IDX_W'(1));

    // Random phases over a spread of window settings.
    run_phase(TICK_W'(0), TICK_W'(1), 1'b0);                  // minimum nonzero span
    run_phase(TICK_W'(TICK_MAX), TICK_W'(TICK_MAX), 1'b1);    // both at max
    run_phase(TICK_W'(0), TICK_W'(TICK_MAX), 1'b0);           // widest window
    run_phase(TICK_W'($urandom_range(100000, 0)), TICK_W'(0), 1'b0);  // zero span
    run_phase(TICK_W'($urandom_range(60000, 0)),
              TICK_W'($urandom_range(2000, LINES_DEF)), 1'b0);
    // span below the line count: lines get skipped between ticks
    run_phase(TICK_W'($urandom_range(120000, 0)),
              TICK_W'($urandom_range(LINES_DEF - 1, 1)), 1'b1);
    run_phase(TICK_W'($urandom), TICK_W'($urandom), 1'b0);
    run_phase(START_RESET, SPAN_RESET, 1'b0);

    // all results in and the block quiet; late strays still get flagged
    wait_idle();
    if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
